// ===== sv/ise_pkg.sv =====
package ise_pkg;

	localparam int ISE_DEPTH     = 64;
	localparam int ISE_WORD_BITS = 32;

	localparam int REQ_W   = 3;
	localparam int DATA_W  = 32;
	localparam int POS_W   = 7;
	localparam int LIMIT_W = 7;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd64;

	localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_CHANGE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DUMP   = 3'd4;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_BAD_POS  = 2'd3
	} ise_status_t;

	typedef struct packed {
		logic [REQ_W-1:0]         req_type;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} ise_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [1:0]               status;
		logic                     last;
	} ise_out_t;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_PUSH,
		DP_POP,
		DP_PEEK,
		DP_DUMP_START,
		DP_DUMP_NEXT
	} ise_dpop_t;

	typedef enum logic [1:0] {
		LD_NONE,
		LD_CONST,
		LD_RAM
	} ise_ld_t;

	typedef struct packed {
		ise_dpop_t   op;
		ise_ld_t     ld;
		ise_status_t status;
		logic        last;
		logic        wr_change;
	} ise_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic pos_bad;
		logic dump_end;
	} ise_stat_t;

endpackage

// ===== sv/ise_ram.sv =====
module ise_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/ise_ctrl.sv =====
module ise_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic [ise_pkg::REQ_W-1:0]    req_type,
	output logic                         req_ready,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	input  ise_pkg::ise_stat_t           stat,
	output ise_pkg::ise_cmd_t            cmd
);

	import ise_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   dump_q, change_q;

	always_comb begin
		state_d       = state_q;
		req_ready     = 1'b0;
		rsp_valid     = 1'b0;
		cmd.op        = DP_NOP;
		cmd.ld        = LD_NONE;
		cmd.status    = ST_OK;
		cmd.last      = 1'b1;
		cmd.wr_change = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (req_type) inside
						REQ_PUSH: begin
							cmd.ld  = LD_CONST;
							state_d = S_OUT;
							if (stat.full) begin
								cmd.status = ST_OVERFLOW;
							end else begin
								cmd.op = DP_PUSH;
							end
						end
						REQ_POP: begin
							if (stat.empty) begin
								cmd.ld     = LD_CONST;
								cmd.status = ST_EMPTY;
								state_d    = S_OUT;
							end else begin
								cmd.op  = DP_POP;
								state_d = S_READ;
							end
						end
						REQ_PEEK, REQ_CHANGE: begin
							if (stat.pos_bad) begin
								cmd.ld     = LD_CONST;
								cmd.status = ST_BAD_POS;
								state_d    = S_OUT;
							end else begin
								cmd.op  = DP_PEEK;
								state_d = S_READ;
							end
						end
						REQ_DUMP: begin
							if (stat.empty) begin
								cmd.ld     = LD_CONST;
								cmd.status = ST_EMPTY;
								state_d    = S_OUT;
							end else begin
								cmd.op  = DP_DUMP_START;
								state_d = S_READ;
							end
						end
						default: begin
							// unknown request: taken, no result
						end
					endcase
				end
			end
			S_READ: begin
				cmd.ld        = LD_RAM;
				cmd.last      = !dump_q || stat.dump_end;
				cmd.wr_change = change_q;
				state_d       = S_OUT;
			end
			S_OUT: begin
				rsp_valid = 1'b1;
				if (rsp_ready) begin
					if (dump_q && !stat.dump_end) begin
						cmd.op  = DP_DUMP_NEXT;
						state_d = S_READ;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			dump_q   <= 1'b0;
			change_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && req_valid) begin
				// an empty dump answers once and never walks the ram
				dump_q   <= (req_type == REQ_DUMP) && !stat.empty;
				change_q <= (req_type == REQ_CHANGE);
			end
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid))
		else $error("request taken while a result is pending");

	a_read_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> state_q == S_OUT)
		else $error("read data not moved to the output register");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_PUSH |-> !stat.full)
		else $error("push issued on a full stack");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !rsp_ready) |=> state_q == S_OUT)
		else $error("result dropped during a stall");

endmodule

// ===== sv/ise_dpath.sv =====
module ise_dpath #(
	parameter int DEPTH     = ise_pkg::ISE_DEPTH,
	parameter int WORD_BITS = ise_pkg::ISE_WORD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [ise_pkg::LIMIT_W-1:0]   cfg_data,
	input  ise_pkg::ise_in_t              req,
	input  ise_pkg::ise_cmd_t             cmd,
	output ise_pkg::ise_stat_t            stat,
	output ise_pkg::ise_out_t             rsp
);

	import ise_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [LIMIT_W-1:0]   size_limit_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     addr_q;
	logic [WORD_BITS-1:0] value_q;
	ise_out_t             res_q;

	logic [LIMIT_W-1:0]   limit;
	logic [CNT_W-1:0]     count_dec;
	logic [POS_W-1:0]     peek_diff;
	logic [IDX_W-1:0]     addr_dec;
	logic [WORD_BITS-1:0] req_word;

	logic                 ram_we, ram_re;
	logic [IDX_W-1:0]     ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

	// limit saturates at the physical depth
	assign limit     = (size_limit_q > LIMIT_W'(DEPTH)) ? LIMIT_W'(DEPTH) : size_limit_q;
	assign count_dec = count_q - CNT_W'(1);
	assign peek_diff = POS_W'(count_q) - req.position;
	assign addr_dec  = addr_q - IDX_W'(1);
	assign req_word  = WORD_BITS'(req.value);

	assign stat.full     = LIMIT_W'(count_q) >= limit;
	assign stat.empty    = (count_q == '0);
	assign stat.pos_bad  = (req.position == '0) || (req.position > POS_W'(count_q));
	assign stat.dump_end = (addr_q == '0);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = value_q;
		ram_re    = 1'b1;
		ram_raddr = count_dec[IDX_W-1:0];
		if (cmd.wr_change) begin
			ram_we = 1'b1;
		end
		case (cmd.op) inside
			DP_PUSH: begin
				ram_we    = 1'b1;
				ram_waddr = count_q[IDX_W-1:0];
				ram_wdata = req_word;
			end
			DP_PEEK:      ram_raddr = peek_diff[IDX_W-1:0];
			DP_DUMP_NEXT: ram_raddr = addr_dec;
			DP_POP, DP_DUMP_START: ram_raddr = count_dec[IDX_W-1:0];
			default:      ram_re = 1'b0;
		endcase
	end

	ise_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_limit_q <= LIMIT_RST;
			count_q      <= '0;
		end else begin
			if (cfg_valid) begin
				size_limit_q <= cfg_data;
			end
			case (cmd.op)
				DP_PUSH: count_q <= count_q + CNT_W'(1);
				DP_POP:  count_q <= count_dec;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_PEEK: begin
				addr_q  <= peek_diff[IDX_W-1:0];
				value_q <= req_word;
			end
			DP_DUMP_START: addr_q <= count_dec[IDX_W-1:0];
			DP_DUMP_NEXT:  addr_q <= addr_dec;
			default: ;
		endcase
		case (cmd.ld)
			LD_CONST: begin
				res_q.data   <= '0;
				res_q.status <= cmd.status;
				res_q.last   <= 1'b1;
			end
			LD_RAM: begin
				res_q.data   <= DATA_W'(ram_rdata);
				res_q.status <= ST_OK;
				res_q.last   <= cmd.last;
			end
			default: ;
		endcase
	end

	assign rsp = res_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_POP |-> count_q != '0)
		else $error("pop on an empty stack");

endmodule

// ===== sv/indexed_stack_engine.sv =====
// channel | valid     | ready     | payload
// req     | req_valid | req_ready | req  (req_type, value, position)
// rsp     | rsp_valid | rsp_ready | rsp  (data, status, last)
// cfg     | cfg_valid | cfg_ready | cfg_data (size_limit)
//
// push and every error answer: result beat in the cycle after the request beat
// pop, peek, change: the registered read of the entry ram, then the output register
// dump: entries top first, read and output alternate
// req_ready is low from an answered request beat until its last result beat is taken
// reset empties the stack and sets the limit to 64; the ram is not cleared
// a stalled result sits in the output register; cfg beats are taken at once
module indexed_stack_engine #(
	parameter int DEPTH     = ise_pkg::ISE_DEPTH,
	parameter int WORD_BITS = ise_pkg::ISE_WORD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  ise_pkg::ise_in_t              req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output ise_pkg::ise_out_t             rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ise_pkg::LIMIT_W-1:0]   cfg_data
);

	import ise_pkg::*;

	ise_cmd_t  cmd;
	ise_stat_t stat;

	assign cfg_ready = 1'b1;

	ise_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ise_dpath #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule

// ===== tb/indexed_stack_engine_tb.sv =====
import ise_pkg::*;

// mirror of the stack: applies each accepted request and queues the answers it must give
class stack_mirror;
	logic signed [DATA_W-1:0] slots [ISE_DEPTH];
	int unsigned              held;
	logic [LIMIT_W-1:0]       limit_reg;
	ise_out_t                 answers_due [$];
	int unsigned              errors;
	int unsigned              answers_seen;
	int unsigned              op_tally [8];
	int unsigned              status_tally [4];
	int unsigned              longest_dump;

	function new();
		held = 0;
		limit_reg = LIMIT_RST;
		errors = 0;
		answers_seen = 0;
		longest_dump = 0;
		foreach (op_tally[i]) op_tally[i] = 0;
		foreach (status_tally[i]) status_tally[i] = 0;
	endfunction

	function void set_limit(logic [LIMIT_W-1:0] v);
		limit_reg = v;
	endfunction

	function void queue_answer(logic signed [DATA_W-1:0] d, ise_status_t s, logic l);
		ise_out_t a;
		a.data = d;
		a.status = s;
		a.last = l;
		answers_due.push_back(a);
		status_tally[s]++;
	endfunction

	function void apply_request(ise_in_t r);
		int unsigned cap;
		int unsigned idx;
		logic signed [DATA_W-1:0] old;
		cap = (limit_reg > ISE_DEPTH) ? ISE_DEPTH : limit_reg;
		op_tally[r.req_type]++;
		case (r.req_type)
			REQ_PUSH: begin
				if (held >= cap) begin
					queue_answer('0, ST_OVERFLOW, 1'b1);
				end else begin
					slots[held] = r.value;
					held++;
					queue_answer('0, ST_OK, 1'b1);
				end
			end
			REQ_POP: begin
				if (held == 0) begin
					queue_answer('0, ST_EMPTY, 1'b1);
				end else begin
					held--;
					queue_answer(slots[held], ST_OK, 1'b1);
				end
			end
			REQ_PEEK, REQ_CHANGE: begin
				if (r.position == 0 || r.position > held) begin
					queue_answer('0, ST_BAD_POS, 1'b1);
				end else begin
					idx = held - r.position;
					old = slots[idx];
					if (r.req_type == REQ_CHANGE)
						slots[idx] = r.value;
					queue_answer(old, ST_OK, 1'b1);
				end
			end
			REQ_DUMP: begin
				if (held == 0) begin
					queue_answer('0, ST_EMPTY, 1'b1);
				end else begin
					for (int i = held; i > 0; i--)
						queue_answer(slots[i-1], ST_OK, i == 1);
					if (held > longest_dump)
						longest_dump = held;
				end
			end
			default: ;
		endcase
	endfunction

	task report(string what);
		errors++;
		if (errors <= 40)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	task check_answer(ise_out_t got);
		ise_out_t want;
		answers_seen++;
		if (answers_due.size() == 0) begin
			report($sformatf("unexpected beat data=%0d status=%0d last=%0b",
				got.data, got.status, got.last));
			return;
		end
		want = answers_due.pop_front();
		if (got.data !== want.data)
			report($sformatf("data %0d, expected %0d", got.data, want.data));
		if (got.status !== want.status)
			report($sformatf("status %0d, expected %0d", got.status, want.status));
		if (got.last !== want.last)
			report($sformatf("last %0b, expected %0b", got.last, want.last));
	endtask
endclass

module indexed_stack_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 300;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	ise_in_t            req = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	ise_out_t           rsp;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] cfg_data = '0;

	bit    steady = 1'b0;
	bit    hold_off_req = 1'b0;
	string limits_log = "64";

	stack_mirror mirror = new();

	indexed_stack_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic ise_in_t req_of(logic [REQ_W-1:0] kind, logic signed [DATA_W-1:0] v,
		logic [POS_W-1:0] p);
		ise_in_t r;
		r.req_type = kind;
		r.value = v;
		r.position = p;
		return r;
	endfunction

	function automatic ise_in_t make_request(int push_pct);
		ise_in_t r;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			r.req_type = REQ_W'($urandom_range(5, 7));
		else if (roll < push_pct)
			r.req_type = REQ_PUSH;
		else begin
			case ($urandom_range(0, 9))
				0, 1, 2: r.req_type = REQ_POP;
				3, 4, 5: r.req_type = REQ_PEEK;
				6, 7, 8: r.req_type = REQ_CHANGE;
				default: r.req_type = REQ_DUMP;
			endcase
		end
		r.value = $urandom;
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0: r.value = 32'sh7fff_ffff;
				1: r.value = 32'sh8000_0000;
				2: r.value = '0;
				default: r.value = '1;
			endcase
		end
		// mostly positions near the filled range, some anywhere
		if ($urandom_range(0, 4) == 0)
			r.position = POS_W'($urandom_range(0, 127));
		else
			r.position = POS_W'($urandom_range(1, mirror.held + 1));
		return r;
	endfunction

	task automatic send_request(ise_in_t item);
		int gap;
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_ready !== 1'b1);
		mirror.apply_request(item);
		gap = idle_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		int waited;
		waited = 0;
		req_valid <= 1'b0;
		while (mirror.answers_due.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] v);
		settle();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		mirror.set_limit(v);
		limits_log = $sformatf("%s,%0d", limits_log, v);
	endtask

	task automatic random_phase(int items, int push_pct, bit hold_midway);
		int done;
		ise_in_t r;
		done = 0;
		while (done < items) begin
			r = make_request(push_pct);
			if (r.req_type <= REQ_DUMP) begin
				done++;
				if (hold_midway && done == items / 3)
					hold_off_req <= 1'b1;
			end
			send_request(r);
		end
	endtask

	// result side: checks every beat and stalls at random
	initial begin : answer_sink
		int stall;
		stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_ready)
				mirror.check_answer(rsp);
			if (stall > 0)
				stall--;
			else if (hold_off_req) begin
				hold_off_req <= 1'b0;
				stall = HOLD_CYCLES;
			end else if (!steady && $urandom_range(0, 3) == 0)
				stall = idle_gap();
			rsp_ready <= (stall == 0);
		end
	end

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack corner cases
		send_request(req_of(REQ_POP, $urandom, 7'd0));
		send_request(req_of(REQ_DUMP, $urandom, 7'd0));
		send_request(req_of(REQ_PEEK, $urandom, 7'd1));
		// value extremes
		send_request(req_of(REQ_PUSH, 32'sh7fff_ffff, 7'd127));
		send_request(req_of(REQ_PUSH, 32'sh8000_0000, 7'd0));
		send_request(req_of(REQ_PUSH, '0, 7'd64));
		send_request(req_of(REQ_PUSH, '1, 7'd1));
		// positions: zero, top, bottom, one past bottom, far out of range, and a middle change
		send_request(req_of(REQ_PEEK, $urandom, 7'd0));
		send_request(req_of(REQ_PEEK, $urandom, 7'd1));
		send_request(req_of(REQ_PEEK, $urandom, 7'd4));
		send_request(req_of(REQ_PEEK, $urandom, 7'd5));
		send_request(req_of(REQ_CHANGE, 32'sh1234_5678, 7'd0));
		send_request(req_of(REQ_CHANGE, 32'sh1234_5678, 7'd127));
		send_request(req_of(REQ_CHANGE, 32'sh1234_5678, 7'd2));
		// unused request codes give no answer
		send_request(req_of(REQ_W'(5), $urandom, 7'd1));
		send_request(req_of(REQ_W'(7), $urandom, 7'd2));
		send_request(req_of(REQ_DUMP, $urandom, 7'd0));
		send_request(req_of(REQ_POP, $urandom, 7'd0));

		// limit below the current fill: entries stay, pushes overflow
		write_limit(7'd1);
		send_request(req_of(REQ_PUSH, 32'sh0000_00a5, 7'd0));
		send_request(req_of(REQ_PEEK, $urandom, 7'd3));
		send_request(req_of(REQ_DUMP, $urandom, 7'd0));

		write_limit(7'd0);
		send_request(req_of(REQ_PUSH, 32'sh5a5a_5a5a, 7'd0));
		send_request(req_of(REQ_POP, $urandom, 7'd0));
		send_request(req_of(REQ_POP, $urandom, 7'd0));
		send_request(req_of(REQ_POP, $urandom, 7'd0));
		send_request(req_of(REQ_POP, $urandom, 7'd0));

		// limit above the store size saturates: fill to the top, with a long result stall
		write_limit(7'd127);
		random_phase(70, 95, 1'b1);

		write_limit(LIMIT_W'($urandom_range(1, 63)));
		random_phase(20, 45, 1'b0);

		// back-to-back beats on both sides
		write_limit(7'd64);
		steady = 1'b1;
		random_phase(20, 40, 1'b0);
		settle();
		steady = 1'b0;
		random_phase(20, 40, 1'b0);

		settle();
		if (mirror.answers_due.size() != 0)
			mirror.report($sformatf("%0d expected beats never arrived",
				mirror.answers_due.size()));

		$display("requests: %0d push, %0d pop, %0d peek, %0d change, %0d dump, %0d ignored",
			mirror.op_tally[REQ_PUSH], mirror.op_tally[REQ_POP], mirror.op_tally[REQ_PEEK],
			mirror.op_tally[REQ_CHANGE], mirror.op_tally[REQ_DUMP],
			mirror.op_tally[5] + mirror.op_tally[6] + mirror.op_tally[7]);
		$display("%0d beats checked (%0d overflow, %0d empty, %0d bad position), %s%0d, limits %s",
			mirror.answers_seen, mirror.status_tally[ST_OVERFLOW],
			mirror.status_tally[ST_EMPTY], mirror.status_tally[ST_BAD_POS],
			"deepest dump ", mirror.longest_dump, limits_log);
		if (mirror.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#25_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
